[rtl/core/prsd_pkg.sv]
// Shared definitions for the palette RLE sprite decoder: field widths,
// operation, register and color mode codes, and the blend unit types.
// No dependencies.
`timescale 1ns / 1ps

package prsd_pkg;

   // Default palette depth, handed to the top-level parameter
   localparam int DEF_PALETTE_DEPTH = 256;

   // Field widths
   localparam int OP_W      = 2;
   localparam int BYTE_W    = 8;
   localparam int COLOR_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int MODE_W    = 2;
   localparam int PIXELS_W  = 25;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 25;
   localparam int SUM_W     = 16;

   // Input operation codes
   localparam logic [OP_W-1:0] OP_PALETTE_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_FRAME_START   = 2'd1;
   localparam logic [OP_W-1:0] OP_FRAME_DATA    = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PIXELS = 2'd2;

   // Color mode: RGB with key blending; bit 1 set swaps red and blue
   localparam logic [MODE_W-1:0] MODE_RGB  = 2'd0;
   localparam int                MODE_SWAP_BIT = 1;

   // Blend unit operands
   typedef struct packed {
      logic [COLOR_W-1:0] pal_color;
      logic [COLOR_W-1:0] key_color;
      logic [CHAN_W-1:0]  alpha;
   } blend_in_type;

   // Per-channel pal*a + key*(255-a), channel 0 is red
   typedef logic [2:0][SUM_W-1:0] blend_sum_type;

endpackage

[rtl/core/palette_rle_sprite_decoder.sv]
// Top level of the palette RLE sprite decoder: byte parser, palette RAM,
// blend pipeline and result register. Depends on prsd_pkg, prsd_ram, prsd_blend.
`timescale 1ns / 1ps

// Takes one item per clock while req_stall is low: palette writes, frame starts
// and compressed frame bytes. The run parser updates its state in the cycle an
// item is accepted, so a new item may follow every cycle. Items that produce a
// pixel, key-run or error result go through three registered stages (palette
// RAM read, blend multiply, divide-by-255 and channel ordering into the result
// register) before they show on rsp_valid.
// The pipeline stages fill bubbles independently; req_stall rises only when all
// of them hold results that rsp_stall is holding back. Configuration writes
// take effect at once and are meant to happen while the pipeline is empty.
// Palette entries that were never written read back as unknown data.
module palette_rle_sprite_decoder #(
   parameter int PALETTE_DEPTH = prsd_pkg::DEF_PALETTE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [prsd_pkg::OP_W-1:0]         req_operation,
   input  logic [prsd_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic [prsd_pkg::BYTE_W-1:0]       req_entry_index,
   input  logic [prsd_pkg::COLOR_W-1:0]      req_entry_color,
   // Result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [prsd_pkg::CHAN_W-1:0]       rsp_chan_first,
   output logic [prsd_pkg::CHAN_W-1:0]       rsp_chan_second,
   output logic [prsd_pkg::CHAN_W-1:0]       rsp_chan_third,
   output logic [prsd_pkg::CHAN_W-1:0]       rsp_chan_alpha,
   output logic [prsd_pkg::BYTE_W-1:0]       rsp_repeat_count,
   output logic                              rsp_overflow_error,
   // Configuration
   input  logic                              csr_write_enable,
   input  logic [prsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [prsd_pkg::CSR_DAT_W-1:0]    csr_write_data
);
   import prsd_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam logic [BYTE_W:0] IDX_LIMIT = (BYTE_W + 1)'(PALETTE_DEPTH);

   typedef enum logic [2:0] {
      PH_COUNT = 3'b001,
      PH_FLAG  = 3'b010,
      PH_INDEX = 3'b100
   } phase_type;

   // Stage 1 carries what is known about a result before the palette read
   typedef struct packed {
      logic              is_pixel;
      logic              is_error;
      logic              out_of_range;
      logic [CHAN_W-1:0] alpha;
      logic [BYTE_W-1:0] count;
   } s1_meta_type;

   // Configuration registers
   logic [MODE_W-1:0]   color_mode_ff;
   logic [COLOR_W-1:0]  key_color_ff;
   logic [PIXELS_W-1:0] frame_pixels_ff;

   // Parser state
   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   run_length_ff, run_length_in;
   logic [CHAN_W-1:0]   run_alpha_ff, run_alpha_in;
   logic [PIXELS_W-1:0] pixels_done_ff, pixels_done_in;
   logic                faulted_ff, faulted_in;

   // Pipeline
   logic                s1_valid_ff, s1_valid_in;
   s1_meta_type         s1_meta_ff, s1_meta_in;
   logic                s2_valid_ff, s2_valid_in;
   logic [COLOR_W-1:0]  s2_color_ff;
   blend_sum_type       s2_sum_ff;
   logic                s2_blend_ff;
   logic [CHAN_W-1:0]   s2_alpha_ff;
   logic [BYTE_W-1:0]   s2_count_ff;
   logic                s2_error_ff;
   logic                out_valid_ff, out_valid_in;
   logic [CHAN_W-1:0]   out_first_ff, out_second_ff, out_third_ff, out_alpha_ff;
   logic [BYTE_W-1:0]   out_count_ff;
   logic                out_error_ff;

   logic                out_free, s2_free, s1_free;
   logic                accept, s1_load, s2_load, out_load;
   logic                push_pixel, push_key, push_error;
   logic                overflow;
   logic [PIXELS_W:0]   run_end;
   logic [BYTE_W-1:0]   run_left;
   logic                pal_wr_en;
   logic [COLOR_W-1:0]  pal_rd_data;
   logic [COLOR_W-1:0]  s1_color;
   blend_in_type        blend_ops;
   blend_sum_type       blend_sums;
   logic [COLOR_W-1:0]  final_color;

   // floor(x/255) for x up to 255*255
   function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
      logic [SUM_W:0] t;
      t = {1'b0, x} + {9'd0, x[SUM_W-1:CHAN_W]} + 17'd1;
      return t[SUM_W-1:CHAN_W];
   endfunction

   // Handshake: each stage moves when the next one is empty or moving
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;
   assign s1_load   = accept && (push_pixel || push_key || push_error);
   assign s2_load   = s1_valid_ff && s2_free;
   assign out_load  = s2_valid_ff && out_free;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff   <= '0;
         key_color_ff    <= '0;
         frame_pixels_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COLOR_MODE:   color_mode_ff   <= csr_write_data[MODE_W-1:0];
            CSR_KEY_COLOR:    key_color_ff    <= csr_write_data[COLOR_W-1:0];
            CSR_FRAME_PIXELS: frame_pixels_ff <= csr_write_data[PIXELS_W-1:0];
            default: ;
         endcase
      end
   end

   // Run parser
   assign run_end  = {1'b0, pixels_done_ff} + (PIXELS_W + 1)'(run_length_ff);
   assign overflow = run_end > {1'b0, frame_pixels_ff};
   assign run_left = run_length_ff - 8'd1;

   always_comb begin
      phase_in       = phase_ff;
      run_length_in  = run_length_ff;
      run_alpha_in   = run_alpha_ff;
      pixels_done_in = pixels_done_ff;
      faulted_in     = faulted_ff;
      push_pixel     = 1'b0;
      push_key       = 1'b0;
      push_error     = 1'b0;
      if (accept && req_operation == OP_FRAME_START) begin
         phase_in       = PH_COUNT;
         run_length_in  = '0;
         run_alpha_in   = '0;
         pixels_done_in = '0;
         faulted_in     = 1'b0;
      end else if (accept && req_operation == OP_FRAME_DATA && !faulted_ff) begin
         unique case (phase_ff)
            PH_FLAG: begin
               if (overflow) begin
                  faulted_in = 1'b1;
                  phase_in   = PH_COUNT;
                  push_error = 1'b1;
               end else begin
                  pixels_done_in = run_end[PIXELS_W-1:0];
                  if (req_data_byte == 8'h00) begin
                     phase_in = PH_COUNT;
                     push_key = (run_length_ff != 8'h00);
                  end else begin
                     run_alpha_in = req_data_byte;
                     phase_in     = (run_length_ff == 8'h00) ? PH_COUNT : PH_INDEX;
                  end
               end
            end
            PH_INDEX: begin
               run_length_in = run_left;
               push_pixel    = 1'b1;
               if (run_left == 8'h00) begin
                  phase_in = PH_COUNT;
               end
            end
            default: begin
               // count byte
               run_length_in = req_data_byte;
               phase_in      = PH_FLAG;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_COUNT;
         run_length_ff  <= '0;
         run_alpha_ff   <= '0;
         pixels_done_ff <= '0;
         faulted_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         run_length_ff  <= run_length_in;
         run_alpha_ff   <= run_alpha_in;
         pixels_done_ff <= pixels_done_in;
         faulted_ff     <= faulted_in;
      end
   end

   // Palette RAM; writes beyond the depth are dropped
   assign pal_wr_en = accept && req_operation == OP_PALETTE_WRITE
                      && ({1'b0, req_entry_index} < IDX_LIMIT);

   prsd_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_entry_index[AW-1:0]),
      .wr_data (req_entry_color),
      .rd_en   (s1_load),
      .rd_addr (req_data_byte[AW-1:0]),
      .rd_data (pal_rd_data)
   );

   // Stage 1: result kind and run fields, palette read in flight
   always_comb begin
      s1_meta_in.is_pixel     = push_pixel;
      s1_meta_in.is_error     = push_error;
      s1_meta_in.out_of_range = !({1'b0, req_data_byte} < IDX_LIMIT);
      s1_meta_in.alpha        = run_alpha_ff;
      s1_meta_in.count        = push_pixel ? 8'd1 : (push_key ? run_length_ff : 8'd0);
   end

   assign s1_valid_in = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_meta_ff <= s1_meta_in;
      end
   end

   // Stage 2: pick the color and form the blend sums
   always_comb begin
      priority if (s1_meta_ff.is_error) begin
         s1_color = '0;
      end else if (!s1_meta_ff.is_pixel) begin
         s1_color = key_color_ff;
      end else if (s1_meta_ff.out_of_range) begin
         s1_color = '0;
      end else begin
         s1_color = pal_rd_data;
      end
   end

   assign blend_ops.pal_color = s1_color;
   assign blend_ops.key_color = key_color_ff;
   assign blend_ops.alpha     = s1_meta_ff.alpha;

   prsd_blend u_blend (
      .operands (blend_ops),
      .sums     (blend_sums)
   );

   assign s2_valid_in = s2_load ? 1'b1 : (out_load ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_color_ff <= s1_color;
         s2_sum_ff   <= blend_sums;
         s2_blend_ff <= s1_meta_ff.is_pixel && (color_mode_ff == MODE_RGB);
         s2_alpha_ff <= (s1_meta_ff.is_pixel && color_mode_ff != MODE_RGB)
                        ? s1_meta_ff.alpha : 8'h00;
         s2_count_ff <= s1_meta_ff.count;
         s2_error_ff <= s1_meta_ff.is_error;
      end
   end

   // Result register: divide by 255 and order the channels
   always_comb begin
      if (s2_blend_ff) begin
         final_color = {div255(s2_sum_ff[2]), div255(s2_sum_ff[1]), div255(s2_sum_ff[0])};
      end else begin
         final_color = s2_color_ff;
      end
   end

   assign out_valid_in = out_load ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (color_mode_ff[MODE_SWAP_BIT]) begin
            out_first_ff <= final_color[23:16];
            out_third_ff <= final_color[7:0];
         end else begin
            out_first_ff <= final_color[7:0];
            out_third_ff <= final_color[23:16];
         end
         out_second_ff <= final_color[15:8];
         out_alpha_ff  <= s2_alpha_ff;
         out_count_ff  <= s2_count_ff;
         out_error_ff  <= s2_error_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_chan_first     = out_first_ff;
   assign rsp_chan_second    = out_second_ff;
   assign rsp_chan_third     = out_third_ff;
   assign rsp_chan_alpha     = out_alpha_ff;
   assign rsp_repeat_count   = out_count_ff;
   assign rsp_overflow_error = out_error_ff;

endmodule

[rtl/core/prsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module prsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/prsd_blend.sv]
// Per-channel weighted sum of palette and key color for RGB blending.
// Depends on prsd_pkg.
`timescale 1ns / 1ps

module prsd_blend (
   input  prsd_pkg::blend_in_type  operands,
   output prsd_pkg::blend_sum_type sums
);
   import prsd_pkg::*;

   logic [CHAN_W-1:0] inv_alpha;

   assign inv_alpha = 8'hFF - operands.alpha;

   // pal*a + key*(255-a), at most 255*255 so it fits in 16 bits
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sums[c] = ({8'd0, operands.pal_color[CHAN_W*c +: CHAN_W]} * {8'd0, operands.alpha})
                 + ({8'd0, operands.key_color[CHAN_W*c +: CHAN_W]} * {8'd0, inv_alpha});
      end
   end

endmodule
